// File: hdl/tmsp_pkg.sv
package tmsp_pkg;

    localparam int PERIOD_W = 12;
    localparam int TIME_W   = 21;
    localparam int PAUSE_W  = 15;

    // One input request: a song character or a one-microsecond tick.
    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
    } t_req;

    // One result per request.
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic refused;
    } t_res;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TONE,
        PH_REST,
        PH_PAUSE
    } t_phase;

    // Position inside the letter, digit, separator triple.
    typedef enum logic [1:0] {
        SLOT_NOTE,
        SLOT_DIGIT,
        SLOT_SEP
    } t_slot;

    // Decoded values of one character, in each of its three roles.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   dur_us;
        logic [PAUSE_W-1:0]  pause_us;
    } t_dec;

    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_G  = 8'h47;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_G  = 8'h67;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef logic [PERIOD_W-1:0] t_period_tbl [7];
    typedef logic [TIME_W-1:0]   t_dur_tbl [10];

    // Periods in microseconds for letters A..G and a..g.
    localparam t_period_tbl UPPER_PERIODS = '{
        12'd2272, 12'd2024, 12'd3816, 12'd3401, 12'd3030, 12'd2865, 12'd2551
    };
    localparam t_period_tbl LOWER_PERIODS = '{
        12'd1136, 12'd1012, 12'd1912, 12'd1703, 12'd1517, 12'd1432, 12'd1275
    };

    // Digit n gives n * 200 ms, held here in microseconds.
    localparam t_dur_tbl DIGIT_DUR_US = '{
        21'd0,       21'd200000,  21'd400000,  21'd600000,  21'd800000,
        21'd1000000, 21'd1200000, 21'd1400000, 21'd1600000, 21'd1800000
    };
    localparam logic [TIME_W-1:0] DEFAULT_DUR_US = 21'd400000;

    localparam logic [PAUSE_W-1:0] PAUSE_NONE_US  = 15'd0;
    localparam logic [PAUSE_W-1:0] PAUSE_SHORT_US = 15'd5000;
    localparam logic [PAUSE_W-1:0] PAUSE_DOT_US   = 15'd20000;
    localparam logic [PAUSE_W-1:0] PAUSE_LONG_US  = 15'd30000;

endpackage

// File: hdl/tmsp_decode.sv
module tmsp_decode (
    input  logic [7:0]     i_char,
    output tmsp_pkg::t_dec o_dec
);

    logic [7:0] up_off;
    logic [7:0] lo_off;

    assign up_off = i_char - tmsp_pkg::CH_UP_A;
    assign lo_off = i_char - tmsp_pkg::CH_LO_A;

    always_comb begin
        // Note letter: anything outside A..G and a..g is a rest.
        if (i_char inside {[tmsp_pkg::CH_UP_A:tmsp_pkg::CH_UP_G]}) begin
            o_dec.period = tmsp_pkg::UPPER_PERIODS[up_off[2:0]];
        end else if (i_char inside {[tmsp_pkg::CH_LO_A:tmsp_pkg::CH_LO_G]}) begin
            o_dec.period = tmsp_pkg::LOWER_PERIODS[lo_off[2:0]];
        end else begin
            o_dec.period = '0;
        end

        // Duration digit: the low nibble of an ASCII digit is its value.
        if (i_char inside {[tmsp_pkg::CH_ZERO:tmsp_pkg::CH_NINE]}) begin
            o_dec.dur_us = tmsp_pkg::DIGIT_DUR_US[i_char[3:0]];
        end else begin
            o_dec.dur_us = tmsp_pkg::DEFAULT_DUR_US;
        end

        // Separator; a comma and any unknown character both give the short pause.
        case (i_char)
            tmsp_pkg::CH_PLUS:  o_dec.pause_us = tmsp_pkg::PAUSE_NONE_US;
            tmsp_pkg::CH_DOT:   o_dec.pause_us = tmsp_pkg::PAUSE_DOT_US;
            tmsp_pkg::CH_UNDER: o_dec.pause_us = tmsp_pkg::PAUSE_LONG_US;
            default:            o_dec.pause_us = tmsp_pkg::PAUSE_SHORT_US;
        endcase
    end

endmodule

// File: hdl/tmsp_core.sv
module tmsp_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  tmsp_pkg::t_req i_req,
    output tmsp_pkg::t_res o_res
);

    tmsp_pkg::t_dec dec;

    tmsp_pkg::t_phase                r_phase, n_phase;
    tmsp_pkg::t_slot                 r_slot, n_slot;
    logic [tmsp_pkg::PERIOD_W-1:0]   r_period, n_period;
    logic [tmsp_pkg::TIME_W-1:0]     r_dur_us, n_dur_us;
    logic [tmsp_pkg::PAUSE_W-1:0]    r_pause_us, n_pause_us;
    logic [tmsp_pkg::TIME_W-1:0]     r_elapsed, n_elapsed;
    logic [tmsp_pkg::TIME_W-1:0]     r_cd, n_cd;
    logic                            r_half_low, n_half_low;
    logic                            r_pin, n_pin;

    logic                            expired;
    logic                            go_pause;
    logic                            refused;
    logic [tmsp_pkg::TIME_W-1:0]     elapsed_sum;
    logic [tmsp_pkg::TIME_W-1:0]     half_period;

    tmsp_decode u_decode (
        .i_char (i_req.char_code),
        .o_dec  (dec)
    );

    assign expired     = (r_cd <= tmsp_pkg::TIME_W'(1));
    assign elapsed_sum = r_elapsed + tmsp_pkg::TIME_W'(r_period);
    assign half_period = tmsp_pkg::TIME_W'(r_period[tmsp_pkg::PERIOD_W-1:1]);

    always_comb begin
        n_phase    = r_phase;
        n_slot     = r_slot;
        n_period   = r_period;
        n_dur_us   = r_dur_us;
        n_pause_us = r_pause_us;
        n_elapsed  = r_elapsed;
        n_cd       = r_cd;
        n_half_low = r_half_low;
        n_pin      = r_pin;
        go_pause   = 1'b0;
        refused    = 1'b0;

        if (i_req.func == tmsp_pkg::FUNC_TICK) begin
            if (r_phase != tmsp_pkg::PH_IDLE) begin
                n_cd = expired ? '0 : r_cd - tmsp_pkg::TIME_W'(1);
                if (expired) begin
                    case (r_phase)
                        tmsp_pkg::PH_TONE: begin
                            if (!r_half_low) begin
                                n_half_low = 1'b1;
                                n_pin      = 1'b0;
                                n_cd       = half_period;
                            end else begin
                                n_elapsed = elapsed_sum;
                                if (elapsed_sum < r_dur_us) begin
                                    n_half_low = 1'b0;
                                    n_pin      = 1'b1;
                                    n_cd       = half_period;
                                end else begin
                                    go_pause = 1'b1;
                                end
                            end
                        end
                        tmsp_pkg::PH_REST: begin
                            go_pause = 1'b1;
                        end
                        default: begin
                            n_phase = tmsp_pkg::PH_IDLE;
                            n_pin   = 1'b0;
                        end
                    endcase
                end
            end
        end else if (r_phase != tmsp_pkg::PH_IDLE) begin
            refused = 1'b1;
        end else if (i_req.char_code == tmsp_pkg::CH_NUL) begin
            n_slot = tmsp_pkg::SLOT_NOTE;
        end else begin
            case (r_slot)
                tmsp_pkg::SLOT_NOTE: begin
                    n_period = dec.period;
                    n_slot   = tmsp_pkg::SLOT_DIGIT;
                end
                tmsp_pkg::SLOT_DIGIT: begin
                    n_dur_us = dec.dur_us;
                    n_slot   = tmsp_pkg::SLOT_SEP;
                end
                default: begin
                    // Separator closes the triple and starts the note; a zero duration goes straight to the pause.
                    n_pause_us = dec.pause_us;
                    n_slot     = tmsp_pkg::SLOT_NOTE;
                    if (r_dur_us == '0) begin
                        go_pause = 1'b1;
                    end else if (r_period != '0) begin
                        n_phase    = tmsp_pkg::PH_TONE;
                        n_elapsed  = '0;
                        n_half_low = 1'b0;
                        n_pin      = 1'b1;
                        n_cd       = half_period;
                    end else begin
                        n_phase = tmsp_pkg::PH_REST;
                        n_pin   = 1'b0;
                        n_cd    = r_dur_us;
                    end
                end
            endcase
        end

        if (go_pause) begin
            n_pin      = 1'b0;
            n_half_low = 1'b0;
            if (n_pause_us == '0) begin
                n_phase = tmsp_pkg::PH_IDLE;
                n_cd    = '0;
            end else begin
                n_phase = tmsp_pkg::PH_PAUSE;
                n_cd    = tmsp_pkg::TIME_W'(n_pause_us);
            end
        end

        o_res.pin_level = n_pin;
        o_res.busy_res  = (n_phase != tmsp_pkg::PH_IDLE);
        o_res.refused   = refused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tmsp_pkg::PH_IDLE;
            r_slot     <= tmsp_pkg::SLOT_NOTE;
            r_period   <= '0;
            r_dur_us   <= '0;
            r_pause_us <= '0;
            r_elapsed  <= '0;
            r_cd       <= '0;
            r_half_low <= 1'b0;
            r_pin      <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_slot     <= n_slot;
            r_period   <= n_period;
            r_dur_us   <= n_dur_us;
            r_pause_us <= n_pause_us;
            r_elapsed  <= n_elapsed;
            r_cd       <= n_cd;
            r_half_low <= n_half_low;
            r_pin      <= n_pin;
        end
    end

endmodule

// File: hdl/text_melody_square_wave_player.sv
// A request accepted into the input register has its result written to the result register.
// Throughput: one request per cycle while the consumer takes results, set by the single
// pass through the player logic between the input register and the result register.
// Reset: synchronous, active low; clears the player to idle with the pin low,
// the triple position at the note letter, and both pipeline registers empty.
module text_melody_square_wave_player (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  tmsp_pkg::t_req i_req,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output tmsp_pkg::t_res o_res
);

    // Input register holds one request until the player has processed it.
    logic           r_in_valid;
    tmsp_pkg::t_req r_in;

    // Result register holds the finished result until the consumer takes it.
    logic           r_out_valid;
    tmsp_pkg::t_res r_out;

    logic           drain;
    tmsp_pkg::t_res core_res;

    // The held request moves on when the result register is empty or is being
    // emptied in this cycle. Only then does the player state advance, so a
    // stalled consumer freezes the song exactly where it is.
    assign drain       = r_in_valid && (!r_out_valid || i_res_ready);

    // A new request is taken whenever the input register is free or moves on now,
    // which lets a request enter in every cycle while results keep flowing.
    assign o_req_ready = !r_in_valid || drain;

    tmsp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (drain),
        .i_req   (r_in),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req_valid && o_req_ready) begin
                r_in_valid <= 1'b1;
            end else if (drain) begin
                r_in_valid <= 1'b0;
            end

            if (drain) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the valid flags guard them.
    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_in <= i_req;
        end
        if (drain) begin
            r_out <= core_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// File: hdl/tmsp_checker.sv
module tmsp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_ready,
    input tmsp_pkg::t_req i_req,
    input logic           o_res_valid,
    input logic           i_res_ready,
    input tmsp_pkg::t_res o_res
);

    // A refused character leaves the player busy.
    a_refused_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.refused |-> o_res.busy_res)
        else $error("refused request reported while idle");

    // The pin is low whenever the player is idle.
    a_idle_pin_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.busy_res |-> !o_res.pin_level)
        else $error("pin high while idle");

    // A result that is not taken stays and holds its value.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result dropped or changed while stalled");

    // No result is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

endmodule

bind text_melody_square_wave_player tmsp_checker u_tmsp_checker (.*);
